### sv/mdfe_pkg.sv
// Shared types and constants for the depth-first maze explorer.
`timescale 1ns / 1ps
package mdfe_pkg;

    localparam int COORD_BITS = 8;
    localparam int DIR_W      = 2;
    localparam int SIDES_W    = 4;
    localparam int STATUS_W   = 3;
    localparam int DEPTH_W    = 9;

    // Directions; the opposite of a direction is its code with bit 0 flipped
    localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
    localparam logic [DIR_W-1:0] DIR_EAST  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FORWARD   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BACKTRACK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ARRIVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    // Input commands
    localparam logic OP_START    = 1'b0;
    localparam logic OP_CONTINUE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd4;

    // One path entry: the move taken and the candidates left behind it
    typedef struct packed {
        logic [DIR_W-1:0]   dir;
        logic [SIDES_W-1:0] saved;
    } stk_entry_t;

    // Shift control shared by every stack cell
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]    path_depth;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_x;
        logic [STATUS_W-1:0]   status;
        logic [DIR_W-1:0]      move_dir;
    } result_t;

endpackage

### sv/maze_depth_first_explorer_unit.sv
// Depth-first maze explorer: step logic, path stack of shifting cells, result buffer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready   | tuser: op; tdata: open_sides
//  m_      | out       | m_tvalid / m_tready   | tuser: status; tdata: dir, x, y, depth
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One step per cycle while s_tready is high: each transfer is resolved in the cycle it is
// accepted, since the top of the path stack sits in the first cell register and push/pop
// shift the whole cell row. Each result is registered in the output or skid register.
// Reset clears position, heading, candidates and stack depth; stack cells are not cleared.
// A two-entry result buffer keeps s_tready high while one result waits on m_tready.
`timescale 1ns / 1ps
module maze_depth_first_explorer_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] open_sides, [7:4] zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] move_dir, [9:2] pos_x, [17:10] pos_y,
                                   // [26:18] path_depth, [31:27] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mdfe_pkg::*;

    localparam int PTR_W = $clog2(STACK_DEPTH + 1);

    // configuration
    logic [COORD_BITS-1:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
    logic [DIR_W-1:0]      start_heading_reg;

    // explorer state
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [DIR_W-1:0]      heading_reg, heading_next;
    logic [SIDES_W-1:0]    cand_reg, cand_next;
    logic                  need_reg, need_next;
    logic [PTR_W-1:0]      sp_reg, sp_next;

    logic                  s_fire;
    logic                  obuf_ready;
    stk_ctrl_t             stk_ctrl;
    stk_entry_t            push_entry;
    stk_entry_t            cells [STACK_DEPTH];
    result_t               res;
    result_t               m_res;
    logic [PTR_W+DEPTH_W-1:0] depth_ext;

    // working values inside the step
    logic [COORD_BITS-1:0] x_eff, y_eff;
    logic [DIR_W-1:0]      hd_eff;
    logic [PTR_W-1:0]      sp_eff;
    logic                  need_eff;
    logic [SIDES_W-1:0]    cand_eff;
    logic [DIR_W-1:0]      pick;
    logic [DIR_W-1:0]      mv;
    logic [DIR_W-1:0]      back;

    assign cfg_ready = 1'b1;
    assign s_tready  = obuf_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            goal_x_reg        <= '0;
            goal_y_reg        <= '0;
            start_heading_reg <= DIR_NORTH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_START_X:       start_x_reg       <= cfg_data;
                CFG_START_Y:       start_y_reg       <= cfg_data;
                CFG_GOAL_X:        goal_x_reg        <= cfg_data;
                CFG_GOAL_Y:        goal_y_reg        <= cfg_data;
                CFG_START_HEADING: start_heading_reg <= cfg_data[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [COORD_BITS-1:0] step_coord(
        input logic [COORD_BITS-1:0] c, input logic up);
        step_coord = up ? c + COORD_BITS'(1) : c - COORD_BITS'(1);
    endfunction

    always_comb begin
        if (s_tuser == OP_START) begin
            x_eff    = start_x_reg;
            y_eff    = start_y_reg;
            hd_eff   = start_heading_reg;
            sp_eff   = '0;
            need_eff = 1'b1;
        end else begin
            x_eff    = cur_x_reg;
            y_eff    = cur_y_reg;
            hd_eff   = heading_reg;
            sp_eff   = sp_reg;
            need_eff = need_reg;
        end
        // drop the side we came in by
        cand_eff = need_eff ? (s_tdata[SIDES_W-1:0] & ~(SIDES_W'(1) << (hd_eff ^ DIR_SOUTH)))
                            : cand_reg;

        if (cand_eff[3])      pick = DIR_WEST;
        else if (cand_eff[2]) pick = DIR_EAST;
        else if (cand_eff[1]) pick = DIR_SOUTH;
        else                  pick = DIR_NORTH;

        back = cells[0].dir ^ DIR_SOUTH;

        push_entry.dir   = pick;
        push_entry.saved = cand_eff & ~(SIDES_W'(1) << pick);

        cur_x_next   = x_eff;
        cur_y_next   = y_eff;
        heading_next = hd_eff;
        cand_next    = cand_eff;
        need_next    = 1'b0;
        sp_next      = sp_eff;
        stk_ctrl     = '0;
        mv           = DIR_NORTH;
        res.status   = ST_ARRIVED;

        if (x_eff == goal_x_reg && y_eff == goal_y_reg) begin
            res.status = ST_ARRIVED;
        end else if (cand_eff != '0) begin
            if (sp_eff == PTR_W'(STACK_DEPTH)) begin
                res.status = ST_OVERFLOW;
            end else begin
                res.status    = ST_FORWARD;
                mv            = pick;
                stk_ctrl.push = 1'b1;
                sp_next       = sp_eff + PTR_W'(1);
                cand_next     = push_entry.saved;
                heading_next  = pick;
                need_next     = 1'b1;
            end
        end else if (sp_eff == '0) begin
            res.status = ST_EXHAUSTED;
        end else begin
            res.status   = ST_BACKTRACK;
            mv           = back;
            stk_ctrl.pop = 1'b1;
            sp_next      = sp_eff - PTR_W'(1);
            cand_next    = cells[0].saved;
            heading_next = back;
        end

        if (res.status == ST_FORWARD || res.status == ST_BACKTRACK) begin
            case (mv)
                DIR_NORTH: cur_y_next = step_coord(y_eff, 1'b1);
                DIR_SOUTH: cur_y_next = step_coord(y_eff, 1'b0);
                DIR_EAST:  cur_x_next = step_coord(x_eff, 1'b1);
                DIR_WEST:  cur_x_next = step_coord(x_eff, 1'b0);
                default: ;
            endcase
        end

        // only shift the cells on an accepted transfer
        stk_ctrl.push = stk_ctrl.push && s_fire;
        stk_ctrl.pop  = stk_ctrl.pop && s_fire;

        depth_ext      = {{DEPTH_W{1'b0}}, sp_next};
        res.move_dir   = mv;
        res.pos_x      = cur_x_next;
        res.pos_y      = cur_y_next;
        res.path_depth = depth_ext[DEPTH_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            heading_reg <= DIR_NORTH;
            cand_reg    <= '0;
            need_reg    <= 1'b1;
            sp_reg      <= '0;
        end else if (s_fire) begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            heading_reg <= heading_next;
            cand_reg    <= cand_next;
            need_reg    <= need_next;
            sp_reg      <= sp_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            stk_entry_t above_w;
            stk_entry_t below_w;
            if (gi == 0) begin : g_top
                assign above_w = push_entry;
            end else begin : g_mid
                assign above_w = cells[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_bot
                assign below_w = '0;
            end else begin : g_up
                assign below_w = cells[gi+1];
            end
            mdfe_cell u_cell (
                .aclk  (aclk),
                .ctrl  (stk_ctrl),
                .above (above_w),
                .below (below_w),
                .entry (cells[gi])
            );
        end
    endgenerate

    mdfe_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (obuf_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    assign m_tuser = m_res.status;
    assign m_tdata = {5'b0, m_res.path_depth, m_res.pos_y, m_res.pos_x, m_res.move_dir};

endmodule

### sv/mdfe_cell.sv
// One cell of the shifting path stack: holds a single path entry.
`timescale 1ns / 1ps
module mdfe_cell (
    input  logic                   aclk,
    input  mdfe_pkg::stk_ctrl_t    ctrl,
    input  mdfe_pkg::stk_entry_t   above,
    input  mdfe_pkg::stk_entry_t   below,
    output mdfe_pkg::stk_entry_t   entry
);
    import mdfe_pkg::*;

    stk_entry_t entry_reg;

    // push takes the neighbour nearer the top, pop the one further down
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entry_reg <= above;
        end else if (ctrl.pop) begin
            entry_reg <= below;
        end
    end

    assign entry = entry_reg;

endmodule

### sv/mdfe_obuf.sv
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps
module mdfe_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  mdfe_pkg::result_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mdfe_pkg::result_t  out_data
);
    import mdfe_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            if (out_valid_reg && !out_ready) begin
                // hold the waiting result, park the new one
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= in_data;
            end else begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= in_data;
            end
        end else if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
